@@ hw/rtl/kct_pkg.sv @@
// Shared types and constants of the k-mer count table.
// Used by kct_ctrl, kct_datapath and kmer_count_table_top. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kct_pkg;

  localparam int KEY_WORDS = 5;
  localparam int KEY_BITS = 64 * KEY_WORDS;
  localparam int COUNT_W = 32;
  localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] THRESH_RESET = 32'd2;

  typedef enum logic [1:0] {
    CMD_BASE  = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Steps of the hash: XOR fold, three partial products of the 64-bit
  // multiply, then the scale to the table depth.
  typedef enum logic [2:0] {
    HS_NONE = 3'd0,
    HS_XOR  = 3'd1,
    HS_P0   = 3'd2,
    HS_P1   = 3'd3,
    HS_P2   = 3'd4,
    HS_P3   = 3'd5,
    HS_P4   = 3'd6
  } hstep_e;

  typedef struct packed {
    logic   accept;
    hstep_e hstep;
    logic   probe_start;
    logic   probe_next;
    logic   mem_rd;
    logic   rd_slot;
    logic   wr_new;
    logic   wr_inc;
    logic   clr_wr;
    logic   ovf_set;
    logic   out_load;
  } ctrl_t;

  typedef struct packed {
    logic will_count;
    logic probe_empty;
    logic probe_match;
    logic probe_last;
    logic clr_last;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic                valid;
    logic [COUNT_W-1:0]  count;
    logic [KEY_BITS-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/kmer_count_table_top.sv @@
// Top level of the k-mer count table: controller plus datapath.
// Depends on kct_pkg, kct_ctrl and kct_datapath.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_ready_o     cmd_i, base_char_i, slot_index_i
//   out      output     out_valid_o / out_ready_i   key_word0..4_o, entry_count_o,
//                                                   occupied_o, kept_o, overflowed_o
//   cfg      input      cfg_valid_i / cfg_ready_o   keep_threshold_i
//
// One request at a time. A character that completes a k-mer goes through the XOR fold,
// the shared 32x32 multiplier and the read-then-compare of the slot memory for each
// slot probed. A slot read does one read of the slot memory; a clear sweeps all slots.
// After reset a clearing sweep of all TABLE_DEPTH slots runs with in_ready_o low. A
// stalled output only holds the next result; the next request is still taken while the
// previous result waits.
`timescale 1ns / 1ps
`default_nettype none

module kmer_count_table_top #(
  parameter int KMER_LEN = 34,
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  base_char_i,
  input  wire logic [11:0] slot_index_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] keep_threshold_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      key_word0_o,
  output logic [63:0]      key_word1_o,
  output logic [63:0]      key_word2_o,
  output logic [63:0]      key_word3_o,
  output logic [63:0]      key_word4_o,
  output logic [31:0]      entry_count_o,
  output logic             occupied_o,
  output logic             kept_o,
  output logic             overflowed_o
);

  kct_pkg::ctrl_t ctrl;
  kct_pkg::stat_t stat;
  kct_pkg::cmd_e  cmd;

  assign cmd = kct_pkg::cmd_e'(cmd_i);
  assign cfg_ready_o = 1'b1;

  kct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  kct_datapath #(
    .KMER_LEN    (KMER_LEN),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .cmd_i            (cmd),
    .base_char_i      (base_char_i),
    .slot_index_i     (slot_index_i),
    .cfg_valid_i      (cfg_valid_i),
    .keep_threshold_i (keep_threshold_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .key_word0_o      (key_word0_o),
    .key_word1_o      (key_word1_o),
    .key_word2_o      (key_word2_o),
    .key_word3_o      (key_word3_o),
    .key_word4_o      (key_word4_o),
    .entry_count_o    (entry_count_o),
    .occupied_o       (occupied_o),
    .kept_o           (kept_o),
    .overflowed_o     (overflowed_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/kct_datapath.sv @@
// Datapath of the k-mer count table: window, hash, slot memory, result register.
// Depends on kct_pkg; driven by kct_ctrl through kct_pkg::ctrl_t.
`timescale 1ns / 1ps
`default_nettype none

module kct_datapath #(
  parameter int KMER_LEN = 34,
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire kct_pkg::ctrl_t               ctrl_i,
  output kct_pkg::stat_t                    stat_o,
  input  wire kct_pkg::cmd_e                cmd_i,
  input  wire logic [7:0]                   base_char_i,
  input  wire logic [11:0]                  slot_index_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [31:0]                  keep_threshold_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [63:0]                       key_word0_o,
  output logic [63:0]                       key_word1_o,
  output logic [63:0]                       key_word2_o,
  output logic [63:0]                       key_word3_o,
  output logic [63:0]                       key_word4_o,
  output logic [31:0]                       entry_count_o,
  output logic                              occupied_o,
  output logic                              kept_o,
  output logic                              overflowed_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(KMER_LEN + 1);
  localparam int WIN_W = 8 * KMER_LEN;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(KMER_LEN);
  localparam logic [FW-1:0] FILL_PRE = FW'(KMER_LEN - 1);
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

  logic [WIN_W-1:0] win_q;
  logic [WIN_W+7:0] win_ext;
  logic [FW-1:0] fill_q;
  logic [kct_pkg::KEY_BITS-1:0] key;
  logic [63:0] h_q;
  logic [63:0] fold;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] prod_q;
  logic [31:0] acc_q;
  logic [AW-1:0] pos_q, probes_q, clr_cnt_q, rd_addr;
  logic [11:0] idx_q;
  logic [31:0] idx_ext;
  logic idx_in_range, is_read_q, ovf_q, hit;
  logic [31:0] thr_q;
  kct_pkg::entry_t slot_mem_q [TABLE_DEPTH];
  kct_pkg::entry_t rd_q, new_entry, inc_entry;
  logic out_valid_q;
  logic [kct_pkg::KEY_BITS-1:0] out_key_q;
  logic [31:0] out_count_q;
  logic out_occ_q, out_kept_q, out_ovf_q;

  // Window shifts toward index zero; the newest character sits at the top.
  assign win_ext = {base_char_i, win_q};
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && cmd_i == kct_pkg::CMD_BASE) begin
      win_q <= win_ext[WIN_W+7:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q <= 1'b0;
      thr_q <= kct_pkg::THRESH_RESET;
    end else begin
      if (ctrl_i.accept && cmd_i == kct_pkg::CMD_BASE && fill_q != FILL_FULL) begin
        fill_q <= fill_q + FW'(1);
      end else if (ctrl_i.accept && cmd_i == kct_pkg::CMD_END) begin
        fill_q <= '0;
      end
      if (ctrl_i.accept && cmd_i == kct_pkg::CMD_CLEAR) begin
        ovf_q <= 1'b0;
      end else if (ctrl_i.ovf_set) begin
        ovf_q <= 1'b1;
      end
      if (cfg_valid_i) begin
        thr_q <= keep_threshold_i;
      end
    end
  end

  assign key = kct_pkg::KEY_BITS'(win_q);

  always_comb begin
    fold = '0;
    for (int w = 0; w < kct_pkg::KEY_WORDS; w++) begin
      fold = fold ^ key[64*w +: 64];
    end
  end

  // One shared 32x32 multiplier; each step uses bits 63:32 or 31:0 of its 64-bit product.
  always_comb begin
    mul_a = acc_q;
    mul_b = DEPTH_W;
    case (ctrl_i.hstep)
      kct_pkg::HS_P0: begin
        mul_a = h_q[31:0];
        mul_b = kct_pkg::HASH_MUL[31:0];
      end
      kct_pkg::HS_P1: begin
        mul_a = h_q[31:0];
        mul_b = kct_pkg::HASH_MUL[63:32];
      end
      kct_pkg::HS_P2: begin
        mul_a = h_q[63:32];
        mul_b = kct_pkg::HASH_MUL[31:0];
      end
      default: begin
        mul_a = acc_q;
        mul_b = DEPTH_W;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i) begin
    case (ctrl_i.hstep)
      kct_pkg::HS_XOR: h_q <= fold;
      kct_pkg::HS_P0: prod_q <= mul_p;
      kct_pkg::HS_P1: begin
        acc_q <= prod_q[63:32];
        prod_q <= mul_p;
      end
      kct_pkg::HS_P2: begin
        acc_q <= acc_q + prod_q[31:0];
        prod_q <= mul_p;
      end
      kct_pkg::HS_P3: acc_q <= acc_q + prod_q[31:0];
      kct_pkg::HS_P4: prod_q <= mul_p;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.probe_start) begin
      pos_q <= prod_q[32 +: AW];
      probes_q <= '0;
    end else if (ctrl_i.probe_next) begin
      pos_q <= (pos_q == LAST_SLOT) ? '0 : pos_q + AW'(1);
      probes_q <= probes_q + AW'(1);
    end
    if (ctrl_i.accept) begin
      idx_q <= slot_index_i;
      is_read_q <= (cmd_i == kct_pkg::CMD_READ);
    end
  end

  assign idx_ext = 32'(idx_q);
  assign idx_in_range = idx_ext < DEPTH_W;
  assign rd_addr = ctrl_i.rd_slot ? idx_ext[AW-1:0] : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clr_wr) begin
      clr_cnt_q <= (clr_cnt_q == LAST_SLOT) ? '0 : clr_cnt_q + AW'(1);
    end
  end

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.count = 32'd1;
    new_entry.key = key;
    inc_entry.valid = 1'b1;
    inc_entry.count = (rd_q.count == kct_pkg::COUNT_MAX) ? rd_q.count
                                                         : rd_q.count + 32'd1;
    inc_entry.key = rd_q.key;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_wr) begin
      slot_mem_q[clr_cnt_q] <= '0;
    end else if (ctrl_i.wr_new) begin
      slot_mem_q[pos_q] <= new_entry;
    end else if (ctrl_i.wr_inc) begin
      slot_mem_q[pos_q] <= inc_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_rd) begin
      rd_q <= slot_mem_q[rd_addr];
    end
  end

  assign hit = is_read_q && idx_in_range && rd_q.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_key_q <= hit ? rd_q.key : '0;
      out_count_q <= hit ? rd_q.count : '0;
      out_occ_q <= hit;
      out_kept_q <= hit && (rd_q.count >= thr_q);
      out_ovf_q <= ovf_q;
    end
  end

  assign stat_o.will_count = (cmd_i == kct_pkg::CMD_BASE) && (fill_q >= FILL_PRE);
  assign stat_o.probe_empty = !rd_q.valid;
  assign stat_o.probe_match = (rd_q.key == key);
  assign stat_o.probe_last = (probes_q == LAST_SLOT);
  assign stat_o.clr_last = (clr_cnt_q == LAST_SLOT);
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign key_word0_o = out_key_q[63:0];
  assign key_word1_o = out_key_q[127:64];
  assign key_word2_o = out_key_q[191:128];
  assign key_word3_o = out_key_q[255:192];
  assign key_word4_o = out_key_q[319:256];
  assign entry_count_o = out_count_q;
  assign occupied_o = out_occ_q;
  assign kept_o = out_kept_q;
  assign overflowed_o = out_ovf_q;

  // A new result must never overwrite one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten while full");

  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.wr_new || ctrl_i.wr_inc) |-> !ctrl_i.clr_wr)
    else $error("table update during clearing sweep");

  a_probe_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.probe_next |=> (pos_q != $past(pos_q)))
    else $error("probe position did not advance");

endmodule

`default_nettype wire

@@ hw/rtl/kct_ctrl.sv @@
// Controller of the k-mer count table: sequences hash, probing, clearing, results.
// Depends on kct_pkg; drives kct_datapath through kct_pkg::ctrl_t.
`timescale 1ns / 1ps
`default_nettype none

module kct_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire kct_pkg::cmd_e  cmd_i,
  input  wire kct_pkg::stat_t stat_i,
  output kct_pkg::ctrl_t      ctrl_o
);

  typedef enum logic [13:0] {
    ST_INIT  = 14'h0001,
    ST_IDLE  = 14'h0002,
    ST_CLEAR = 14'h0004,
    ST_XOR   = 14'h0008,
    ST_P0    = 14'h0010,
    ST_P1    = 14'h0020,
    ST_P2    = 14'h0040,
    ST_P3    = 14'h0080,
    ST_P4    = 14'h0100,
    ST_HOME  = 14'h0200,
    ST_RD    = 14'h0400,
    ST_CHK   = 14'h0800,
    ST_RSLOT = 14'h1000,
    ST_DONE  = 14'h2000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    ctrl_o.hstep = kct_pkg::HS_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctrl_o.accept = in_valid_i;
        if (in_valid_i) begin
          case (cmd_i)
            kct_pkg::CMD_BASE:  state_d = stat_i.will_count ? ST_XOR : ST_DONE;
            kct_pkg::CMD_END:   state_d = ST_DONE;
            kct_pkg::CMD_READ:  state_d = ST_RSLOT;
            kct_pkg::CMD_CLEAR: state_d = ST_CLEAR;
            default:            state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = ST_DONE;
      end
      ST_XOR: begin
        ctrl_o.hstep = kct_pkg::HS_XOR;
        state_d = ST_P0;
      end
      ST_P0: begin
        ctrl_o.hstep = kct_pkg::HS_P0;
        state_d = ST_P1;
      end
      ST_P1: begin
        ctrl_o.hstep = kct_pkg::HS_P1;
        state_d = ST_P2;
      end
      ST_P2: begin
        ctrl_o.hstep = kct_pkg::HS_P2;
        state_d = ST_P3;
      end
      ST_P3: begin
        ctrl_o.hstep = kct_pkg::HS_P3;
        state_d = ST_P4;
      end
      ST_P4: begin
        ctrl_o.hstep = kct_pkg::HS_P4;
        state_d = ST_HOME;
      end
      ST_HOME: begin
        ctrl_o.probe_start = 1'b1;
        state_d = ST_RD;
      end
      ST_RD: begin
        ctrl_o.mem_rd = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (stat_i.probe_empty) begin
          ctrl_o.wr_new = 1'b1;
          state_d = ST_DONE;
        end else if (stat_i.probe_match) begin
          ctrl_o.wr_inc = 1'b1;
          state_d = ST_DONE;
        end else if (stat_i.probe_last) begin
          // Every slot holds some other key: drop this k-mer.
          ctrl_o.ovf_set = 1'b1;
          state_d = ST_DONE;
        end else begin
          ctrl_o.probe_next = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_RSLOT: begin
        ctrl_o.mem_rd = 1'b1;
        ctrl_o.rd_slot = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.accept |=> (state_q != ST_IDLE))
    else $error("request accepted without leaving idle");

  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |=> in_ready_o)
    else $error("block not ready after result load");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.wr_new, ctrl_o.wr_inc, ctrl_o.clr_wr, ctrl_o.ovf_set}))
    else $error("conflicting table actions");

endmodule

`default_nettype wire

@@ tb/sv/kct_checker.sv @@
// Checker for the k-mer count table: watches the request, result and threshold channels,
// keeps its own copy of the table and compares every result. Depends on kct_pkg.
`timescale 1ns / 1ps

module kct_checker #(
  parameter int KLEN  = 34,
  parameter int DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  base_char_i,
  input  logic [11:0] slot_index_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] keep_threshold_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] key_word0_i,
  input  logic [63:0] key_word1_i,
  input  logic [63:0] key_word2_i,
  input  logic [63:0] key_word3_i,
  input  logic [63:0] key_word4_i,
  input  logic [31:0] entry_count_i,
  input  logic        occupied_i,
  input  logic        kept_i,
  input  logic        overflowed_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int HOLD = 16;

  typedef struct packed {
    logic [kct_pkg::KEY_BITS-1:0] key;
    logic [31:0]                  count;
    logic                         occupied;
    logic                         kept;
    logic                         overflowed;
  } slot_view_t;

  logic [7:0]                   window_q [KLEN];
  int                           fill_q;
  logic [kct_pkg::KEY_BITS-1:0] keys_q [DEPTH];
  logic [31:0]                  counts_q [DEPTH];
  logic                         used_q [DEPTH];
  logic                         ovf_q;
  logic [31:0]                  thresh_q;
  slot_view_t                   held_q [HOLD];
  int                           held_wr, held_rd, held_cnt;

  assign pending_o = held_cnt;

  function automatic int home_of(logic [kct_pkg::KEY_BITS-1:0] key);
    logic [63:0]  folded;
    logic [127:0] scaled;
    folded = '0;
    for (int w = 0; w < kct_pkg::KEY_WORDS; w++) folded ^= key[64*w +: 64];
    folded = folded * kct_pkg::HASH_MUL;
    scaled = {96'd0, folded[63:32]} * DEPTH;
    return int'(scaled[63:32]) % DEPTH;
  endfunction

  task automatic count_kmer();
    logic [kct_pkg::KEY_BITS-1:0] key;
    int                           pos;
    key = '0;
    for (int i = 0; i < KLEN && i < kct_pkg::KEY_WORDS * 8; i++) key[8*i +: 8] = window_q[i];
    pos = home_of(key);
    for (int n = 0; n < DEPTH; n++) begin
      if (!used_q[pos]) begin
        keys_q[pos] = key;
        counts_q[pos] = 32'd1;
        used_q[pos] = 1'b1;
        return;
      end
      if (keys_q[pos] == key) begin
        if (counts_q[pos] != kct_pkg::COUNT_MAX) counts_q[pos]++;
        return;
      end
      pos = (pos + 1) % DEPTH;
    end
    ovf_q = 1'b1;
  endtask

  task automatic store_expected(slot_view_t v);
    held_q[held_wr] = v;
    held_wr = (held_wr + 1) % HOLD;
    held_cnt++;
  endtask

  task automatic apply_request(kct_pkg::cmd_e cmd, logic [7:0] ch, logic [11:0] idx);
    slot_view_t v;
    v = '0;
    case (cmd)
      kct_pkg::CMD_BASE: begin
        if (fill_q >= KLEN) begin
          for (int i = 0; i < KLEN - 1; i++) window_q[i] = window_q[i+1];
          window_q[KLEN-1] = ch;
        end else begin
          window_q[fill_q] = ch;
          fill_q++;
        end
        if (fill_q >= KLEN) count_kmer();
      end
      kct_pkg::CMD_END: fill_q = 0;
      kct_pkg::CMD_CLEAR: begin
        foreach (used_q[i]) used_q[i] = 1'b0;
        ovf_q = 1'b0;
      end
      default: begin
        if (int'(idx) < DEPTH && used_q[idx]) begin
          v.key = keys_q[idx];
          v.count = counts_q[idx];
          v.occupied = 1'b1;
          v.kept = counts_q[idx] >= thresh_q;
        end
      end
    endcase
    v.overflowed = ovf_q;
    store_expected(v);
  endtask

  task automatic report_mismatch(string what, logic [kct_pkg::KEY_BITS-1:0] got,
                                 logic [kct_pkg::KEY_BITS-1:0] exp);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp);
    fail_count_o++;
  endtask

  task automatic check_result();
    slot_view_t e;
    if (held_cnt == 0) begin
      report_mismatch("unexpected result", '0, '0);
      return;
    end
    e = held_q[held_rd];
    held_rd = (held_rd + 1) % HOLD;
    held_cnt--;
    if (key_word0_i !== e.key[63:0])    report_mismatch("key_word0", key_word0_i, e.key[63:0]);
    if (key_word1_i !== e.key[127:64])  report_mismatch("key_word1", key_word1_i, e.key[127:64]);
    if (key_word2_i !== e.key[191:128]) report_mismatch("key_word2", key_word2_i, e.key[191:128]);
    if (key_word3_i !== e.key[255:192]) report_mismatch("key_word3", key_word3_i, e.key[255:192]);
    if (key_word4_i !== e.key[319:256]) report_mismatch("key_word4", key_word4_i, e.key[319:256]);
    if (entry_count_i !== e.count) report_mismatch("entry_count", entry_count_i, e.count);
    if (occupied_i !== e.occupied) report_mismatch("occupied", occupied_i, e.occupied);
    if (kept_i !== e.kept) report_mismatch("kept", kept_i, e.kept);
    if (overflowed_i !== e.overflowed) report_mismatch("overflowed", overflowed_i, e.overflowed);
  endtask

  initial begin
    fail_count_o = 0;
    fill_q = 0;
    ovf_q = 1'b0;
    thresh_q = kct_pkg::THRESH_RESET;
    held_wr = 0;
    held_rd = 0;
    held_cnt = 0;
    foreach (used_q[i]) used_q[i] = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) thresh_q = keep_threshold_i;
      if (in_valid_i && in_ready_i) begin
        apply_request(kct_pkg::cmd_e'(cmd_i), base_char_i, slot_index_i);
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the k-mer count table: drives requests and threshold writes with
// random gaps and stalls, and gives the verdict. Depends on kct_pkg and kct_checker.
`timescale 1ns / 1ps

module tb;

  localparam int KLEN = 34;
  localparam int DEPTH = 4096;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 160;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = kct_pkg::CMD_END;
  logic [7:0]  base_char = '0;
  logic [11:0] slot_index = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] thresh = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] kw0, kw1, kw2, kw3, kw4;
  logic [31:0] entry_count;
  logic        occupied, kept, overflowed;
  int          fail_count, pending;
  int          cycle_count = 0;
  int          sent = 0;
  logic [7:0]  motif [KLEN + 8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  kmer_count_table_top #(.KMER_LEN(KLEN), .TABLE_DEPTH(DEPTH)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .base_char_i(base_char), .slot_index_i(slot_index),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .keep_threshold_i(thresh),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .key_word0_o(kw0), .key_word1_o(kw1), .key_word2_o(kw2), .key_word3_o(kw3),
    .key_word4_o(kw4), .entry_count_o(entry_count), .occupied_o(occupied),
    .kept_o(kept), .overflowed_o(overflowed)
  );

  kct_checker #(.KLEN(KLEN), .DEPTH(DEPTH)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .cmd_i(cmd),
    .base_char_i(base_char), .slot_index_i(slot_index),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .keep_threshold_i(thresh),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .key_word0_i(kw0), .key_word1_i(kw1), .key_word2_i(kw2), .key_word3_i(kw3),
    .key_word4_i(kw4), .entry_count_i(entry_count), .occupied_i(occupied),
    .kept_i(kept), .overflowed_i(overflowed),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls for a random number of cycles before each result.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      repeat (stall) @(posedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      out_ready <= 1'b0;
    end
  end

  // Valid stays high after an accept only when the next request follows with no gap.
  task automatic send_request(kct_pkg::cmd_e c, logic [7:0] ch, logic [11:0] idx,
                              bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    base_char <= ch;
    slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    wait_drained();
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    thresh <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A sequence built from a short repeating motif so that k-mers recur and counts grow.
  task automatic send_sequence(int length, int period);
    for (int i = 0; i < period; i++) motif[i] = 8'($urandom);
    for (int i = 0; i < length; i++) send_request(kct_pkg::CMD_BASE, motif[i % period], '0);
    send_request(kct_pkg::CMD_END, '0, '0);
  endtask

  task automatic read_random_slots(int n);
    for (int i = 0; i < n; i++) send_request(kct_pkg::CMD_READ, '0, 12'($urandom));
  endtask

  initial begin
    int pick;
    int phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short sequence, extremes of the fields, every command.
    send_request(kct_pkg::CMD_READ, 8'hFF, 12'd0);
    send_request(kct_pkg::CMD_READ, 8'h00, 12'hFFF);
    for (int i = 0; i < 5; i++) send_request(kct_pkg::CMD_BASE, 8'hFF, '0);
    send_request(kct_pkg::CMD_END, '0, '0);
    for (int i = 0; i < KLEN + 2; i++) begin
      send_request(kct_pkg::CMD_BASE, (i % 2) ? 8'h00 : 8'hFF, '0, 1);
    end
    send_request(kct_pkg::CMD_END, '0, '0);
    for (int i = 0; i < DEPTH; i += 256) send_request(kct_pkg::CMD_READ, '0, 12'(i + 255), 1);
    send_request(kct_pkg::CMD_CLEAR, '0, '0);
    send_request(kct_pkg::CMD_READ, '0, 12'd4095);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_threshold(32'd1);
        1: write_threshold(32'hFFFF_FFFF);
        2: write_threshold(32'd3);
        3: write_threshold(32'd0);
        default: write_threshold(32'($urandom_range(1, 8)));
      endcase
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          send_sequence($urandom_range(KLEN, KLEN + 30), $urandom_range(1, 8));
        end else if (pick < 8) begin
          read_random_slots(8);
        end else if (pick == 8) begin
          send_sequence($urandom_range(1, KLEN - 1), $urandom_range(1, 40));
        end else begin
          send_request(kct_pkg::cmd_e'($urandom_range(0, 2)), 8'($urandom), 12'($urandom));
        end
      end
      // Read back every sixteenth slot of the table, in phase 2 only, to keep the run short.
      if (phase == 2) begin
        for (int i = 0; i < DEPTH; i += 16) send_request(kct_pkg::CMD_READ, '0, 12'(i), 1);
      end
      if (phase == 3) send_request(kct_pkg::CMD_CLEAR, '0, '0);
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
